### rtl/u8e_pkg.sv
`default_nettype none

package u8e_pkg;

  // Outcome of scanning the bytes of one candidate sequence.
  typedef enum logic [1:0] {
    SEQ_BAD,
    SEQ_PART,
    SEQ_DONE
  } seq_res_e;

  // Sequencer state of the back end.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_e;

  typedef struct packed {
    seq_res_e   res;
    logic [2:0] len;
  } cls_t;

  // One queued input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } q_item_t;

  typedef logic [3:0][7:0] byte_buf_t;

  localparam logic [7:0] ESC_LEAD  = 8'hEE;
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LOW_MASK  = 8'h3F;

  // Escape phases: lead byte, high bits of the raw byte, low six bits.
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Classify the first n bytes of b under strict UTF-8 rules.
  function automatic cls_t classify(input byte_buf_t b, input logic [2:0] n);
    logic [2:0] need;
    logic [7:0] lo2;
    logic [7:0] hi2;
    logic       bad;
    cls_t       r;
    bad  = 1'b0;
    need = 3'd1;
    lo2  = CONT_LO;
    hi2  = CONT_HI;
    if (b[0] < 8'h80) begin
      need = 3'd1;
    end else if (b[0] inside {[8'hC2:8'hDF]}) begin
      need = 3'd2;
    end else if (b[0] inside {[8'hE0:8'hEF]}) begin
      need = 3'd3;
      if (b[0] == 8'hE0) lo2 = 8'hA0;
      if (b[0] == 8'hED) hi2 = 8'h9F;
    end else if (b[0] inside {[8'hF0:8'hF4]}) begin
      need = 3'd4;
      if (b[0] == 8'hF0) lo2 = 8'h90;
      if (b[0] == 8'hF4) hi2 = 8'h8F;
    end else begin
      bad = 1'b1;
    end
    if (need > 3'd1 && n > 3'd1 && (b[1] < lo2 || b[1] > hi2)) bad = 1'b1;
    if (need > 3'd2 && n > 3'd2 && (b[2] < CONT_LO || b[2] > CONT_HI)) bad = 1'b1;
    if (need > 3'd3 && n > 3'd3 && (b[3] < CONT_LO || b[3] > CONT_HI)) bad = 1'b1;
    r.len = need;
    if (bad) begin
      r.res = SEQ_BAD;
    end else if (n < need) begin
      r.res = SEQ_PART;
    end else begin
      r.res = SEQ_DONE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/u8e_in_if.sv
`default_nettype none

interface u8e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

`default_nettype wire

### rtl/u8e_out_if.sv
`default_nettype none

interface u8e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       output_end;

  modport source (output valid, output out_byte, output run_last, output output_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input output_end,
                output ready);
endinterface

`default_nettype wire

### rtl/utf8_invalid_byte_escaper.sv
// Flow: an input byte is written into the front queue, then loaded into the back-end buffer, and
// its first output byte is registered from there; a byte that is only held gives no output.
// Sequencing: the back-end sequencer loads an item in ST_IDLE, then in ST_RUN either checks
// that the byte is only held or emits its output bytes (up to twelve), waiting whenever the
// output stalls; it takes no new item from the queue until it is back in ST_IDLE.
// Reset: rst_ni clears the queue, the held-byte count and the output valid asynchronously.
`default_nettype none

module utf8_invalid_byte_escaper import u8e_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  u8e_in_if.sink     in_i,
  u8e_out_if.source  out_o
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // Front end: accepts transfers into a short queue.
  u8e_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back end: scans held bytes and emits the escaped stream.
  u8e_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

### rtl/u8e_front.sv
`default_nettype none

module u8e_front import u8e_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  u8e_in_if.sink   in_i,
  output logic     q_valid_o,
  output q_item_t  q_item_o,
  input  wire      q_pop_i
);

  q_item_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  // The front accepts a transfer whenever the two-entry queue has room.
  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{in_byte: in_i.in_byte, string_end: in_i.string_end};
    end
  end

endmodule

`default_nettype wire

### rtl/u8e_back.sv
`default_nettype none

module u8e_back import u8e_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        q_valid_i,
  input  q_item_t    q_item_i,
  output logic       q_pop_o,
  u8e_out_if.source  out_o
);

  back_state_e state_q, state_d;
  byte_buf_t   buf_q, buf_d;
  logic [2:0]  n_q, n_d;
  logic        last_q, last_d;
  logic [1:0]  phase_q, phase_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        run_last_q, run_last_d;
  logic        out_end_q, out_end_d;

  cls_t        cls0;
  cls_t        cls1;
  logic        escape;
  logic [2:0]  adv;
  byte_buf_t   rem_buf;
  logic [2:0]  rem_n;
  logic [2:0]  rem_idx [4];
  logic        slot_free;
  logic        chunk_end;
  logic        rem_done;

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.run_last   = run_last_q;
  assign out_o.output_end = out_end_q;
  assign slot_free        = !out_valid_q || out_o.ready;

  // Scan the current buffer, then look ahead at what stays after this chunk.
  assign cls0   = classify(buf_q, n_q);
  assign escape = (cls0.res != SEQ_DONE);
  assign adv    = escape ? 3'd1 : cls0.len;
  assign rem_n  = n_q - adv;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_idx[i] = 3'(i) + adv;
      rem_buf[i] = (rem_idx[i] < 3'd4) ? buf_q[rem_idx[i][1:0]] : 8'h00;
    end
  end

  assign cls1     = classify(rem_buf, rem_n);
  assign rem_done = (rem_n == 3'd0) || (cls1.res == SEQ_PART && !last_q);
  assign chunk_end = escape ? (phase_q == PH_LOW)
                            : ({1'b0, phase_q} == cls0.len - 3'd1);

  // Next state, buffer update and output byte selection.
  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    n_d         = n_q;
    last_d      = last_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    out_end_d   = out_end_q;
    q_pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o             = 1'b1;
          buf_d[n_q[1:0]]     = q_item_i.in_byte;
          n_d                 = n_q + 3'd1;
          last_d              = q_item_i.string_end;
          phase_d             = PH_LEAD;
          state_d             = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cls0.res == SEQ_PART && !last_q) begin
          // An unfinished sequence is held for the next item.
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          if (escape) begin
            case (phase_q)
              PH_LEAD: out_byte_d = ESC_LEAD;
              PH_HIGH: out_byte_d = CONT_MARK | {6'b0, buf_q[0][7:6]};
              default: out_byte_d = CONT_MARK | (buf_q[0] & LOW_MASK);
            endcase
          end else begin
            out_byte_d = buf_q[phase_q];
          end
          run_last_d = chunk_end && rem_done;
          out_end_d  = chunk_end && rem_done && last_q;
          if (chunk_end) begin
            buf_d   = rem_buf;
            n_d     = rem_n;
            phase_d = PH_LEAD;
            if (rem_done) begin
              state_d = ST_IDLE;
            end
          end else begin
            phase_d = phase_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= 3'd0;
      last_q      <= 1'b0;
      phase_q     <= PH_LEAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      last_q      <= last_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Held bytes and the output payload carry no reset.
  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    out_end_q  <= out_end_d;
  end

endmodule

`default_nettype wire

### verif/utf8_invalid_byte_escaper_tb.sv
`timescale 1ns / 100ps

module utf8_invalid_byte_escaper_tb;
  import u8e_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_BYTES = 90;
  localparam int CALM_TAIL = 30;
  localparam int DIR_ROWS = 25;

  // One byte of the input string, with an optional typed expectation.
  typedef struct packed {
    logic [7:0]  in_byte;
    logic        string_end;
    logic        typed;
    logic [1:0]  typed_n;
    logic [23:0] typed_bytes;
  } stim_t;

  // One byte of the escaped output stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       output_end;
  } esc_byte_t;

  typedef logic [3:0][7:0] seq_bytes_t;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   err_cnt;
  int   cycle_cnt;

  u8e_in_if  in_if ();
  u8e_out_if out_if ();

  utf8_invalid_byte_escaper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Directed rows: extremes, each invalid lead class, the range limits of the
  // second byte after E0, ED and F4, a flush at string end and the longest rescan.
  stim_t dir_tbl [DIR_ROWS] = '{
    '{8'h01, 1'b0, 1'b1, 2'd1, 24'h01_0000},   // lowest byte
    '{8'h7F, 1'b1, 1'b1, 2'd1, 24'h7F_0000},   // highest ASCII, ends a string
    '{8'h80, 1'b0, 1'b1, 2'd3, 24'hEE_82_80},  // stray continuation byte
    '{8'hFF, 1'b0, 1'b1, 2'd3, 24'hEE_83_BF},  // highest byte
    '{8'hC0, 1'b0, 1'b1, 2'd3, 24'hEE_83_80},  // overlong two-byte lead
    '{8'hC1, 1'b0, 1'b1, 2'd3, 24'hEE_83_81},
    '{8'hF5, 1'b0, 1'b1, 2'd3, 24'hEE_83_B5},  // lead beyond U+10FFFF
    '{8'hC2, 1'b0, 1'b1, 2'd0, 24'h0},         // held, nothing out
    '{8'h80, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'hE0, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h9F, 1'b0, 1'b0, 2'd0, 24'h0},         // overlong three-byte form
    '{8'hED, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hA0, 1'b0, 1'b0, 2'd0, 24'h0},         // surrogate
    '{8'hF4, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h8F, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 24'h0},         // U+10FFFF passes
    '{8'hF4, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h90, 1'b0, 1'b0, 2'd0, 24'h0},         // above U+10FFFF
    '{8'hE2, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h82, 1'b1, 1'b0, 2'd0, 24'h0},         // partial sequence flushed
    '{8'hF1, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h80, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h80, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hC0, 1'b1, 1'b0, 2'd0, 24'h0}          // four escapes from one byte
  };

  stim_t     stim_q [$];
  esc_byte_t escaped_q [$];

  // Predictor state: the unfinished sequence carried between bytes.
  logic [7:0] held_seq [3];
  int         held_n;
  logic [7:0] step_out [12];
  int         step_n;

  // Classify the first n bytes of b; len is the sequence length when done.
  function automatic seq_res_e scan_seq(input seq_bytes_t b, input int n, output int len);
    int         need;
    logic [7:0] lo;
    logic [7:0] hi;
    lo  = 8'h80;
    hi  = 8'hBF;
    len = 0;
    if (b[0] < 8'h80) need = 1;
    else if (b[0] >= 8'hC2 && b[0] <= 8'hDF) need = 2;
    else if (b[0] >= 8'hE0 && b[0] <= 8'hEF) need = 3;
    else if (b[0] >= 8'hF0 && b[0] <= 8'hF4) need = 4;
    else return SEQ_BAD;
    // The second byte has tighter limits for the overlong, surrogate and top leads.
    if (b[0] == 8'hE0) lo = 8'hA0;
    if (b[0] == 8'hED) hi = 8'h9F;
    if (b[0] == 8'hF0) lo = 8'h90;
    if (b[0] == 8'hF4) hi = 8'h8F;
    for (int k = 1; k < need && k < n; k++) begin
      if (k > 1) begin
        lo = 8'h80;
        hi = 8'hBF;
      end
      if (b[k] < lo || b[k] > hi) return SEQ_BAD;
    end
    if (n < need) return SEQ_PART;
    len = need;
    return SEQ_DONE;
  endfunction

  // Work out the output bytes of one input byte and update the held sequence.
  task automatic escape_step(input logic [7:0] in_byte, input logic last);
    seq_bytes_t b;
    int         n;
    int         len;
    seq_res_e   r;
    logic [7:0] c;
    step_n = 0;
    b = '0;
    for (int k = 0; k < held_n; k++) b[k] = held_seq[k];
    b[held_n] = in_byte;
    n = held_n + 1;
    while (n > 0) begin
      r = scan_seq(b, n, len);
      if (r == SEQ_DONE) begin
        for (int k = 0; k < len; k++) begin
          step_out[step_n] = b[k];
          step_n++;
        end
      end else if (r == SEQ_PART && !last) begin
        break;
      end else begin
        // Escape the lead byte into the private use area and rescan the rest.
        c = b[0];
        step_out[step_n]     = ESC_LEAD;
        step_out[step_n + 1] = CONT_MARK | (c >> 6);
        step_out[step_n + 2] = CONT_MARK | (c & LOW_MASK);
        step_n += 3;
        len = 1;
      end
      b = b >> (8 * len);
      n -= len;
    end
    held_n = n;
    for (int k = 0; k < n; k++) held_seq[k] = b[k];
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reset is asserted once at the start.
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output ready with random stall bursts, none in the calm tail.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected byte.
  always @(posedge clk_i) begin
    esc_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (escaped_q.size() == 0) begin
        $error("out_byte: expected none, got %h", out_if.out_byte);
        err_cnt++;
      end else begin
        want = escaped_q.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_if.out_byte);
          err_cnt++;
        end
        if (out_if.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_if.run_last);
          err_cnt++;
        end
        if (out_if.output_end !== want.output_end) begin
          $error("output_end: expected %b, got %b", want.output_end, out_if.output_end);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: directed rows, then random strings, then drain and verdict.
  initial begin
    stim_t      item;
    logic [7:0] seq [4];
    int         seq_len;
    int         kind;
    int         nchars;
    int         rand_cnt;
    esc_byte_t  beat;

    in_if.valid      <= 1'b0;
    in_if.in_byte    <= 8'h01;
    in_if.string_end <= 1'b0;
    calm      = 1'b0;
    held_n    = 0;
    rand_cnt  = 0;

    foreach (dir_tbl[i]) stim_q = {stim_q, dir_tbl[i]};

    // Random strings: mostly well-formed characters, some noise and broken ones.
    while (rand_cnt < RAND_BYTES) begin
      nchars = $urandom_range(1, 8);
      for (int s = 0; s < nchars; s++) begin
        kind = $urandom_range(0, 9);
        seq_len = 1;
        if (kind <= 2) begin
          seq[0] = 8'($urandom_range(1, 127));
        end else if (kind == 3) begin
          seq[0] = 8'($urandom_range(1, 255));
        end else begin
          seq_len = $urandom_range(2, 4);
          case (seq_len)
            2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
            3: seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
            default: seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
          endcase
          for (int k = 1; k < seq_len; k++) seq[k] = 8'($urandom_range(8'h80, 8'hBF));
          if (seq[0] == 8'hE0) seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
          if (seq[0] == 8'hED) seq[1] = 8'($urandom_range(8'h80, 8'h9F));
          if (seq[0] == 8'hF0) seq[1] = 8'($urandom_range(8'h90, 8'hBF));
          if (seq[0] == 8'hF4) seq[1] = 8'($urandom_range(8'h80, 8'h8F));
          // Broken characters: cut short or with a corrupted trailing byte.
          if (kind == 9) begin
            if ($urandom_range(0, 1) == 1) seq_len--;
            else seq[$urandom_range(1, seq_len - 1)] = 8'($urandom_range(1, 255));
          end
        end
        for (int k = 0; k < seq_len; k++) begin
          item = '0;
          item.in_byte = seq[k];
          stim_q = {stim_q, item};
          rand_cnt++;
        end
      end
      stim_q[stim_q.size() - 1].string_end = 1'b1;
    end

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    foreach (stim_q[i]) begin
      item = stim_q[i];
      if (i >= stim_q.size() - CALM_TAIL) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      in_if.valid      <= 1'b1;
      in_if.in_byte    <= item.in_byte;
      in_if.string_end <= item.string_end;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);

      // Transfer taken: queue its expected output bytes.
      escape_step(item.in_byte, item.string_end);
      if (item.typed) begin
        step_n = int'(item.typed_n);
        for (int k = 0; k < step_n; k++) step_out[k] = item.typed_bytes[23 - 8 * k -: 8];
      end
      for (int k = 0; k < step_n; k++) begin
        beat.out_byte   = step_out[k];
        beat.run_last   = (k == step_n - 1);
        beat.output_end = (k == step_n - 1) && item.string_end;
        escaped_q = {escaped_q, beat};
      end
    end
    in_if.valid <= 1'b0;

    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
